>>> rtl/dprd_pkg.sv
`timescale 1ns / 1ps

package dprd_pkg;

    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int GAIN_FRAC_BITS_DEF = 24;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [7:0] COUNT_MAX = 8'd255;
    localparam logic [7:0] DRIVE_MIN = 8'd5;
    localparam logic [7:0] DRIVE_MAX = 8'd250;

    localparam logic [15:0]        TARGET_RST     = 16'd4000;
    localparam logic signed [31:0] GAIN_P_RST     = 32'sd167772;
    localparam logic signed [31:0] GAIN_I_RST     = 32'sd3355;
    localparam logic signed [31:0] GAIN_D_RST     = 32'sd335544;
    localparam logic [7:0]         MAX_STEP_RST   = 8'd80;
    localparam logic [15:0]        DEAD_ZONE_RST  = 16'd55;
    localparam logic [7:0]         DECIMATION_RST = 8'd4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TARGET     = 3'd0,
        REG_GAIN_P     = 3'd1,
        REG_GAIN_I     = 3'd2,
        REG_GAIN_D     = 3'd3,
        REG_MAX_STEP   = 3'd4,
        REG_DEAD_ZONE  = 3'd5,
        REG_DECIMATION = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [15:0]        target;
        logic signed [31:0] gain_p;
        logic signed [31:0] gain_i;
        logic signed [31:0] gain_d;
        logic [7:0]         max_step;
        logic [15:0]        dead_zone;
        logic [7:0]         decimation;
    } cfg_t;

endpackage

>>> rtl/dprd_front.sv
`timescale 1ns / 1ps

module dprd_front #(
    parameter int SAMPLE_BITS = dprd_pkg::SAMPLE_BITS_DEF,
    localparam int ERR_W  = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1,
    localparam int SUM_W  = ERR_W + 2,
    localparam int DIFF_W = ERR_W + 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dprd_pkg::cfg_t           cfg,
    input  logic [SAMPLE_BITS-1:0]   sample,
    input  logic                     sample_valid,
    output logic                     sample_ready,
    output logic                     err_valid,
    input  logic                     err_ready,
    output logic signed [ERR_W-1:0]  err,
    output logic signed [SUM_W-1:0]  err_sum,
    output logic signed [DIFF_W-1:0] err_diff,
    output logic                     dead
);

    logic [7:0]              count_reg;
    logic [7:0]              count_inc;
    logic                    fire;
    logic                    take;
    logic signed [ERR_W-1:0] last_error_reg;
    logic signed [ERR_W-1:0] prior_error_reg;
    logic signed [ERR_W-1:0] err_next;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [DIFF_W-1:0] diff_next;
    logic [ERR_W-1:0]        mag;
    logic                    dead_next;
    logic                    valid_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic                     dead_reg;

    assign sample_ready = !valid_reg || err_ready;
    assign take         = sample_valid && sample_ready;

    // counter saturates at the top instead of wrapping
    assign count_inc = (count_reg == dprd_pkg::COUNT_MAX) ? count_reg : count_reg + 8'd1;
    assign fire      = (count_inc >= cfg.decimation);

    always_comb
    begin
        err_next = $signed({{(ERR_W-16){1'b0}}, cfg.target})
                 - $signed({{(ERR_W-SAMPLE_BITS){1'b0}}, sample});
        sum_next = {{2{prior_error_reg[ERR_W-1]}}, prior_error_reg}
                 + {{2{last_error_reg[ERR_W-1]}}, last_error_reg}
                 + {{2{err_next[ERR_W-1]}}, err_next};
        diff_next = {err_next[ERR_W-1], err_next}
                  - {last_error_reg[ERR_W-1], last_error_reg};
        mag       = err_next[ERR_W-1] ? ERR_W'(-err_next) : ERR_W'(err_next);
        dead_next = (mag < {{(ERR_W-16){1'b0}}, cfg.dead_zone});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            last_error_reg  <= '0;
            prior_error_reg <= '0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                count_reg <= fire ? 8'd0 : count_inc;
                if (fire)
                begin
                    last_error_reg  <= err_next;
                    prior_error_reg <= last_error_reg;
                end
            end
            if (take && fire)
            begin
                valid_reg <= 1'b1;
            end
            else if (err_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && fire)
        begin
            err_reg  <= err_next;
            sum_reg  <= sum_next;
            diff_reg <= diff_next;
            dead_reg <= dead_next;
        end
    end

    assign err_valid = valid_reg;
    assign err       = err_reg;
    assign err_sum   = sum_reg;
    assign err_diff  = diff_reg;
    assign dead      = dead_reg;

    // an update beat can only follow a sample that fired
    a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !$past(valid_reg)) |-> $past(take && fire))
        else $error("update beat without firing sample");

    // firing clears the count, otherwise it moves by at most one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (count_reg == 8'd0) || (count_reg == $past(count_inc)))
        else $error("sample count mismatch");

    a_history_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (take && fire) |=> (prior_error_reg == $past(last_error_reg)))
        else $error("error history not shifted");

endmodule

>>> rtl/dprd_law.sv
`timescale 1ns / 1ps

module dprd_law #(
    parameter int SAMPLE_BITS    = dprd_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = dprd_pkg::GAIN_FRAC_BITS_DEF,
    localparam int ERR_W  = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1,
    localparam int SUM_W  = ERR_W + 2,
    localparam int DIFF_W = ERR_W + 1,
    localparam int PROD_W = 32 + SUM_W,
    localparam int ACC_W  = PROD_W + 2,
    localparam int Q_W    = ACC_W - GAIN_FRAC_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dprd_pkg::cfg_t           cfg,
    input  logic                     err_valid,
    output logic                     err_ready,
    input  logic signed [ERR_W-1:0]  err,
    input  logic signed [SUM_W-1:0]  err_sum,
    input  logic signed [DIFF_W-1:0] err_diff,
    input  logic                     dead,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic [7:0]               drive,
    output logic signed [8:0]        step
);

    logic                     prod_valid_reg;
    logic                     acc_valid_reg;
    logic                     out_valid_reg;
    logic                     prod_ready;
    logic                     acc_ready;
    logic                     out_ready;

    logic signed [PROD_W-1:0] pp_reg, pi_reg, pd_reg;
    logic signed [PROD_W-1:0] pp_next, pi_next, pd_next;
    logic                     dead_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    logic signed [Q_W-1:0]    q_floor;
    logic                     q_up;
    logic signed [Q_W-1:0]    q;
    logic signed [Q_W-1:0]    lim;
    logic signed [8:0]        step_next;
    logic signed [10:0]       drv_sum;
    logic [7:0]               drive_next;
    logic [7:0]               drive_level_reg;
    logic signed [8:0]        step_reg;

    assign out_ready  = !out_valid_reg || result_ready;
    assign acc_ready  = !acc_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || acc_ready;
    assign err_ready  = prod_ready;

    // operands sign-extended to the product width before multiplying
    always_comb
    begin
        pp_next = $signed({{(PROD_W-32){cfg.gain_p[31]}}, cfg.gain_p})
                * $signed({{(PROD_W-ERR_W){err[ERR_W-1]}}, err});
        pi_next = $signed({{(PROD_W-32){cfg.gain_i[31]}}, cfg.gain_i})
                * $signed({{(PROD_W-SUM_W){err_sum[SUM_W-1]}}, err_sum});
        pd_next = $signed({{(PROD_W-32){cfg.gain_d[31]}}, cfg.gain_d})
                * $signed({{(PROD_W-DIFF_W){err_diff[DIFF_W-1]}}, err_diff});
        acc_next = dead_reg ? '0
                 : ({{2{pp_reg[PROD_W-1]}}, pp_reg}
                  + {{2{pi_reg[PROD_W-1]}}, pi_reg}
                  + {{2{pd_reg[PROD_W-1]}}, pd_reg});
    end

    // divide by 2^frac, rounding toward zero: floor plus one when negative and inexact
    always_comb
    begin
        q_floor = Q_W'(acc_reg >>> GAIN_FRAC_BITS);
        q_up    = acc_reg[ACC_W-1] && (|acc_reg[GAIN_FRAC_BITS-1:0]);
        q       = q_floor + $signed({{(Q_W-1){1'b0}}, q_up});
        lim     = $signed({{(Q_W-8){1'b0}}, cfg.max_step});
        if (q > lim)
            step_next = 9'(lim);
        else if (q < -lim)
            step_next = 9'(-lim);
        else
            step_next = 9'(q);
        drv_sum = $signed({3'b000, drive_level_reg}) + $signed({{2{step_next[8]}}, step_next});
        if (drv_sum > $signed({3'b000, dprd_pkg::DRIVE_MAX}))
            drive_next = dprd_pkg::DRIVE_MAX;
        else if (drv_sum < $signed({3'b000, dprd_pkg::DRIVE_MIN}))
            drive_next = dprd_pkg::DRIVE_MIN;
        else
            drive_next = drv_sum[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg  <= 1'b0;
            acc_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            drive_level_reg <= '0;
        end
        else
        begin
            if (prod_ready)
                prod_valid_reg <= err_valid;
            if (acc_ready)
                acc_valid_reg <= prod_valid_reg;
            if (out_ready)
                out_valid_reg <= acc_valid_reg;
            if (out_ready && acc_valid_reg)
                drive_level_reg <= drive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_ready && err_valid)
        begin
            pp_reg   <= pp_next;
            pi_reg   <= pi_next;
            pd_reg   <= pd_next;
            dead_reg <= dead;
        end
        if (acc_ready && prod_valid_reg)
            acc_reg <= acc_next;
        if (out_ready && acc_valid_reg)
            step_reg <= step_next;
    end

    assign result_valid = out_valid_reg;
    assign drive        = drive_level_reg;
    assign step         = step_reg;

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((step_reg <= $signed({1'b0, cfg.max_step}))
                        && (step_reg >= -$signed({1'b0, cfg.max_step}))))
        else $error("step beyond rate limit");

    a_drive_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((drive_level_reg >= dprd_pkg::DRIVE_MIN)
                        && (drive_level_reg <= dprd_pkg::DRIVE_MAX)))
        else $error("drive outside clamp range");

    // a fresh beat after a taken one must come out of the accumulator stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_ready) |=> (!out_valid_reg || $past(acc_valid_reg)))
        else $error("result beat from empty stage");

endmodule

>>> rtl/decimated_pid_rate_limited_drive_core.sv
`timescale 1ns / 1ps

// Decimated PID drive controller. Accepts one sample per cycle unless stalled;
// every Nth sample (N = decimation, 0 or 1 = every sample) produces one result beat
// carrying the new drive level (clamped to 5..250) and the rate-limited step.
// A result is presented after its sample passes four register stages: the sample
// counter and error history, the three parallel gain products, the accumulator, then
// step and drive clamping in the output register. Throughput is one sample per
// cycle while result_ready is high. Config registers are written through
// wr_en/wr_index/wr_data and should only change while no update is in flight.
module decimated_pid_rate_limited_drive_core #(
    parameter int SAMPLE_BITS    = dprd_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = dprd_pkg::GAIN_FRAC_BITS_DEF,
    localparam int ERR_W  = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1,
    localparam int SUM_W  = ERR_W + 2,
    localparam int DIFF_W = ERR_W + 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [dprd_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [dprd_pkg::CFG_DATA_W-1:0]  wr_data,
    input  logic [SAMPLE_BITS-1:0]           sample,
    input  logic                             sample_valid,
    output logic                             sample_ready,
    output logic [7:0]                       drive,
    output logic signed [8:0]                step,
    output logic                             result_valid,
    input  logic                             result_ready
);

    dprd_pkg::cfg_t           cfg_reg;
    logic                     err_valid;
    logic                     err_ready;
    logic signed [ERR_W-1:0]  err;
    logic signed [SUM_W-1:0]  err_sum;
    logic signed [DIFF_W-1:0] err_diff;
    logic                     dead;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target     <= dprd_pkg::TARGET_RST;
            cfg_reg.gain_p     <= dprd_pkg::GAIN_P_RST;
            cfg_reg.gain_i     <= dprd_pkg::GAIN_I_RST;
            cfg_reg.gain_d     <= dprd_pkg::GAIN_D_RST;
            cfg_reg.max_step   <= dprd_pkg::MAX_STEP_RST;
            cfg_reg.dead_zone  <= dprd_pkg::DEAD_ZONE_RST;
            cfg_reg.decimation <= dprd_pkg::DECIMATION_RST;
        end
        else if (wr_en)
        begin
            unique case (dprd_pkg::reg_index_t'(wr_index))
                dprd_pkg::REG_TARGET:     cfg_reg.target     <= wr_data[15:0];
                dprd_pkg::REG_GAIN_P:     cfg_reg.gain_p     <= $signed(wr_data);
                dprd_pkg::REG_GAIN_I:     cfg_reg.gain_i     <= $signed(wr_data);
                dprd_pkg::REG_GAIN_D:     cfg_reg.gain_d     <= $signed(wr_data);
                dprd_pkg::REG_MAX_STEP:   cfg_reg.max_step   <= wr_data[7:0];
                dprd_pkg::REG_DEAD_ZONE:  cfg_reg.dead_zone  <= wr_data[15:0];
                dprd_pkg::REG_DECIMATION: cfg_reg.decimation <= wr_data[7:0];
                default: ;
            endcase
        end
    end

    dprd_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample       (sample),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .err_valid    (err_valid),
        .err_ready    (err_ready),
        .err          (err),
        .err_sum      (err_sum),
        .err_diff     (err_diff),
        .dead         (dead)
    );

    dprd_law #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_law (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .err_valid    (err_valid),
        .err_ready    (err_ready),
        .err          (err),
        .err_sum      (err_sum),
        .err_diff     (err_diff),
        .dead         (dead),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .drive        (drive),
        .step         (step)
    );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 10;     // covers the four-stage pipeline
    localparam int STALL_LIMIT   = 5000;
    localparam int TARGET_BEATS  = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SW            = dprd_pkg::SAMPLE_BITS_DEF;

    // index past the end of the register map, must be ignored
    localparam logic [dprd_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef struct {
        logic [7:0]        drive;
        logic signed [8:0] step;
    } drive_update_t;

    class drive_scoreboard;
        dprd_pkg::cfg_t     cfg;
        logic [7:0]         sample_count;
        logic signed [16:0] last_err;
        logic signed [16:0] prior_err;
        logic [7:0]         drive_level;
        drive_update_t      pending_updates[$];
        int errors, n_beats, n_updates, n_dead, n_limited, n_checked;

        function void reset_state();
            cfg.target     = dprd_pkg::TARGET_RST;
            cfg.gain_p     = dprd_pkg::GAIN_P_RST;
            cfg.gain_i     = dprd_pkg::GAIN_I_RST;
            cfg.gain_d     = dprd_pkg::GAIN_D_RST;
            cfg.max_step   = dprd_pkg::MAX_STEP_RST;
            cfg.dead_zone  = dprd_pkg::DEAD_ZONE_RST;
            cfg.decimation = dprd_pkg::DECIMATION_RST;
            sample_count   = '0;
            last_err       = '0;
            prior_err      = '0;
            drive_level    = '0;
        endfunction

        function void write_reg(logic [dprd_pkg::CFG_INDEX_W-1:0] idx,
                                logic [dprd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                dprd_pkg::REG_TARGET:     cfg.target     = data[15:0];
                dprd_pkg::REG_GAIN_P:     cfg.gain_p     = data;
                dprd_pkg::REG_GAIN_I:     cfg.gain_i     = data;
                dprd_pkg::REG_GAIN_D:     cfg.gain_d     = data;
                dprd_pkg::REG_MAX_STEP:   cfg.max_step   = data[7:0];
                dprd_pkg::REG_DEAD_ZONE:  cfg.dead_zone  = data[15:0];
                dprd_pkg::REG_DECIMATION: cfg.decimation = data[7:0];
                default: ;
            endcase
        endfunction

        // Advance the controller by one accepted sample; queue a result on an update.
        function void note_sample(logic [SW-1:0] smp);
            longint err, window, diff, mag, acc, delta, lim, level;
            drive_update_t upd;
            n_beats++;
            if (sample_count < dprd_pkg::COUNT_MAX)
                sample_count++;
            if (sample_count < cfg.decimation)
                return;
            sample_count = '0;

            err    = longint'(cfg.target) - longint'(smp);
            window = longint'(prior_err) + longint'(last_err) + err;
            diff   = err - longint'(last_err);
            prior_err = last_err;
            last_err  = err[16:0];

            mag = (err < 0) ? -err : err;
            if (mag < longint'(cfg.dead_zone))
            begin
                delta = 0;
                n_dead++;
            end
            else
            begin
                acc = longint'($signed(cfg.gain_p)) * err
                    + longint'($signed(cfg.gain_i)) * window
                    + longint'($signed(cfg.gain_d)) * diff;
                // signed divide truncates toward zero
                delta = acc / (longint'(1) << dprd_pkg::GAIN_FRAC_BITS_DEF);
            end

            lim = longint'(cfg.max_step);
            if (delta > lim || delta < -lim)
                n_limited++;
            if (delta > lim)
                delta = lim;
            if (delta < -lim)
                delta = -lim;

            level = longint'(drive_level) + delta;
            if (level > longint'(dprd_pkg::DRIVE_MAX))
                level = longint'(dprd_pkg::DRIVE_MAX);
            if (level < longint'(dprd_pkg::DRIVE_MIN))
                level = longint'(dprd_pkg::DRIVE_MIN);
            drive_level = level[7:0];

            upd.drive = level[7:0];
            upd.step  = delta[8:0];
            pending_updates.push_back(upd);
            n_updates++;
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_update(logic [7:0] drv, logic [8:0] stp);
            drive_update_t want;
            if (pending_updates.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat drive=%0d step=%0d",
                                          drv, $signed(stp)));
                return;
            end
            want = pending_updates.pop_front();
            n_checked++;
            if (drv !== want.drive)
                report_mismatch($sformatf("update %0d drive got %0d want %0d",
                                          n_checked, drv, want.drive));
            if (stp !== want.step)
                report_mismatch($sformatf("update %0d step got %0d want %0d",
                                          n_checked, $signed(stp), want.step));
        endtask
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             wr_en;
    logic [dprd_pkg::CFG_INDEX_W-1:0] wr_index;
    logic [dprd_pkg::CFG_DATA_W-1:0]  wr_data;
    logic [SW-1:0]                    sample;
    logic                             sample_valid;
    logic                             sample_ready;
    logic [7:0]                       drive;
    logic signed [8:0]                step;
    logic                             result_valid;
    logic                             result_ready;

    drive_scoreboard sb;
    int gap_pct;
    int stall_pct;
    int hold_cycles;
    int quiet_cycles;

    decimated_pid_rate_limited_drive_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .sample       (sample),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .drive        (drive),
        .step         (step),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // result side: check accepted beats, then pick next ready
    initial
    begin
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
                sb.check_update(drive, step);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || wr_en || (sample_valid && sample_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d updates outstanding",
                     STALL_LIMIT, sb.pending_updates.size());
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // drop valid, wait for every queued update, then let the pipeline drain
    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (sb.pending_updates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [dprd_pkg::CFG_INDEX_W-1:0] idx,
                             logic [dprd_pkg::CFG_DATA_W-1:0] data);
        wait_idle();
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        wr_en <= 1'b0;
    endtask

    // narrow registers get junk in the unused upper bits
    task automatic program_regs(logic [15:0] sp, logic [31:0] gp, logic [31:0] gi,
                                logic [31:0] gd, logic [7:0] ms, logic [15:0] dz,
                                logic [7:0] dec);
        cfg_write(dprd_pkg::REG_TARGET,     {16'($urandom), sp});
        cfg_write(dprd_pkg::REG_GAIN_P,     gp);
        cfg_write(dprd_pkg::REG_GAIN_I,     gi);
        cfg_write(dprd_pkg::REG_GAIN_D,     gd);
        cfg_write(dprd_pkg::REG_MAX_STEP,   {24'($urandom), ms});
        cfg_write(dprd_pkg::REG_DEAD_ZONE,  {16'($urandom), dz});
        cfg_write(dprd_pkg::REG_DECIMATION, {24'($urandom), dec});
    endtask

    task automatic send_sample(logic [SW-1:0] value);
        while ($urandom_range(99) < gap_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= value;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        sb.note_sample(value);
    endtask

    function automatic logic [31:0] pick_gain(logic [31:0] nominal);
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            3: return nominal;
            4: return -nominal;
            default: return 32'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
        endcase
    endfunction

    initial
    begin
        int phase, n_items, r, v, sp, dz;
        bit pressure;
        logic [7:0] dec, ms;
        logic [15:0] sp_cfg, dz_cfg;

        sb = new();
        sb.reset_state();
        rst_n        <= 1'b0;
        wr_en        <= 1'b0;
        wr_index     <= '0;
        wr_data      <= '0;
        sample       <= '0;
        sample_valid <= 1'b0;
        gap_pct      = 0;
        stall_pct    = 0;
        hold_cycles  = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nominal gains, every sample: dead zone edges and the lower drive clamp
        program_regs(16'd4000, dprd_pkg::GAIN_P_RST, dprd_pkg::GAIN_I_RST,
                     dprd_pkg::GAIN_D_RST, 8'd80, 16'd55, 8'd1);
        send_sample(16'd4000);
        send_sample(16'd4054);
        send_sample(16'd3945);
        repeat (3) send_sample(16'd0);
        repeat (3) send_sample(16'hFFFF);
        cfg_write(dprd_pkg::REG_DECIMATION, 32'd0);
        send_sample(16'd4100);
        send_sample(16'd3900);

        // extreme gains and the widest step limit
        program_regs(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 8'd255, 16'd0, 8'd1);
        send_sample(16'd0);
        send_sample(16'hFFFF);
        program_regs(16'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 8'd255, 16'd0, 8'd1);
        send_sample(16'hFFFF);
        send_sample(16'd0);

        // widest dead zone, step limit of zero
        program_regs(16'd0, dprd_pkg::GAIN_P_RST, dprd_pkg::GAIN_I_RST,
                     dprd_pkg::GAIN_D_RST, 8'd0, 16'hFFFF, 8'd1);
        send_sample(16'hFFFF);
        send_sample(16'd100);

        // decimation lowered below the running count; unmapped write ignored
        cfg_write(dprd_pkg::REG_DECIMATION, 32'd8);
        repeat (3) send_sample(16'($urandom));
        cfg_write(REG_UNMAPPED, 32'd1);
        cfg_write(dprd_pkg::REG_DECIMATION, 32'd2);
        send_sample(16'd1234);

        phase = 0;
        while (sb.n_beats < TARGET_BEATS)
        begin
            pressure = (phase == 2);
            case (phase % 4)
                0:
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct = 65;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct = 0;
                    stall_pct = 65;
                end
                default:
                begin
                    gap_pct = 17;
                    stall_pct = 17;
                end
            endcase

            if (pressure)
                dec = 8'd1;
            else if (phase == 5)
                dec = 8'd255;
            else if (phase % 3 == 0)
                dec = 8'($urandom_range(0, 1));
            else if (phase % 7 == 4)
                dec = 8'd40;
            else
                dec = 8'($urandom_range(2, 12));

            case ($urandom_range(0, 5))
                0: sp_cfg = 16'd0;
                1: sp_cfg = 16'hFFFF;
                default: sp_cfg = 16'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0: ms = 8'd0;
                1: ms = 8'd255;
                default: ms = 8'($urandom_range(1, 120));
            endcase
            case ($urandom_range(0, 7))
                0: dz_cfg = 16'd0;
                1: dz_cfg = 16'hFFFF;
                default: dz_cfg = 16'($urandom_range(0, 200));
            endcase
            program_regs(sp_cfg, pick_gain(dprd_pkg::GAIN_P_RST),
                         pick_gain(dprd_pkg::GAIN_I_RST),
                         pick_gain(dprd_pkg::GAIN_D_RST), ms, dz_cfg, dec);

            if (pressure)
            begin
                gap_pct = 0;
                hold_cycles = HOLD_CYCLES;
            end

            n_items = (dec == 8'd255) ? 300 : 150;
            sp = int'(sb.cfg.target);
            dz = int'(sb.cfg.dead_zone);
            repeat (n_items)
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    v = sp + int'($urandom_range(0, 1200)) - 600;
                else if (r < 70)
                    v = sp + ($urandom_range(0, 1) ? dz : -dz) + int'($urandom_range(0, 2)) - 1;
                else if (r < 80)
                    v = $urandom_range(0, 1) ? 0 : 65535;
                else
                    v = int'($urandom_range(0, 65535));
                if (v < 0)
                    v = 0;
                if (v > 65535)
                    v = 65535;
                send_sample(v[SW-1:0]);
            end
            phase++;
        end

        wait_idle();
        if (sb.pending_updates.size() != 0)
            sb.report_mismatch($sformatf("%0d updates never arrived",
                                         sb.pending_updates.size()));
        $display("Ran %0d sample beats over %0d config phases; %0d updates checked",
                 sb.n_beats, phase, sb.n_checked);
        $display("  %0d inside the dead zone, %0d rate-limited, %0d mismatches",
                 sb.n_dead, sb.n_limited, sb.errors);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
